// File: rtl/aesp_pkg.sv
// Package for the escape sequence parser: result kinds, control table,
// character constants and the saturating decimal accumulate step.
// Depends on nothing.
`default_nettype none

package aesp_pkg;

	typedef enum logic [3:0] {
		KIND_ERASE_DISP = 4'd0,
		KIND_ERASE_LINE = 4'd1,
		KIND_SCROLL     = 4'd2,
		KIND_SAVE       = 4'd3,
		KIND_RESTORE    = 4'd4,
		KIND_ROW_ABS    = 4'd5,
		KIND_ROW_REL    = 4'd6,
		KIND_OTHER      = 4'd7,
		KIND_INVALID    = 4'd8
	} kind_t;

	typedef struct packed {
		logic       found;
		logic [5:0] id;
	} ctl_hit_t;

	localparam int NUM_CTL = 35;
	localparam logic [5:0] ID_CSI = 6'd11;
	localparam logic [5:0] ID_G0  = 6'd18;
	localparam logic [5:0] ID_G3  = 6'd21;

	localparam logic [7:0] KEY_ESC    = 8'h1B;
	localparam logic [7:0] FINAL_LO   = 8'h40;
	localparam logic [7:0] FINAL_HI   = 8'h7E;
	localparam logic [7:0] CH_J       = 8'h4A;
	localparam logic [7:0] CH_K       = 8'h4B;
	localparam logic [7:0] CH_S       = 8'h53;
	localparam logic [7:0] CH_T       = 8'h54;
	localparam logic [7:0] CH_LS      = 8'h73;
	localparam logic [7:0] CH_LU      = 8'h75;
	localparam logic [7:0] CH_LD      = 8'h64;
	localparam logic [7:0] CH_LE      = 8'h65;
	localparam logic [7:0] CH_QUERY   = 8'h3F;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_WS_LO   = 8'h09;
	localparam logic [7:0] CH_WS_HI   = 8'h0D;

	localparam logic [15:0] SAT_MAX = 16'hFFFF;

	// D E H M N O P V W X Z [ \ ] _ space # % ( ) * + 7 8 = > F c l m n o | } ~
	localparam logic [7:0] CTL_TAB [NUM_CTL] = '{
		8'h44, 8'h45, 8'h48, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h56, 8'h57, 8'h58,
		8'h5A, 8'h5B, 8'h5C, 8'h5D, 8'h5F, 8'h20, 8'h23, 8'h25, 8'h28, 8'h29,
		8'h2A, 8'h2B, 8'h37, 8'h38, 8'h3D, 8'h3E, 8'h46, 8'h63, 8'h6C, 8'h6D,
		8'h6E, 8'h6F, 8'h7C, 8'h7D, 8'h7E
	};

	function automatic ctl_hit_t ctl_lookup(input logic [7:0] b);
		ctl_hit_t h;
		h.found = 1'b0;
		h.id    = '0;
		for (int i = NUM_CTL - 1; i >= 0; i--) begin
			if (CTL_TAB[i] == b) begin
				h.found = 1'b1;
				h.id    = 6'(i);
			end
		end
		return h;
	endfunction

	function automatic logic [15:0] sat_acc(input logic [15:0] v, input logic [3:0] d);
		logic [19:0] r;
		r = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {16'b0, d};
		return (r > {4'b0, SAT_MAX}) ? SAT_MAX : r[15:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/ansi_escape_sequence_parser_unit.sv
// Escape sequence parser top level: input register, parser state and result register.
// Depends on aesp_pkg.
`default_nettype none

// Takes one byte per transfer and may take a new byte in every cycle while s_axis_tready
// is high. The byte that causes a result is held in the input register, then the
// combinational parser update writes the result register. Bytes that only advance a
// sequence give no result. Backpressure on the master side stalls the input only once
// both the input register and the result register are full.
// Result tdata packs kind, erase_mode, amount, control_id and charset_byte.
module ansi_escape_sequence_parser_unit #(
	parameter int MAX_SEQ_LEN = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata   // [3:0] kind, [5:4] erase_mode,
	                                        // [22:6] amount, [28:23] control_id,
	                                        // [36:29] charset_byte, [39:37] zero
);

	localparam int SEQ_W = $clog2(MAX_SEQ_LEN + 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ESC,
		PH_DESIG,
		PH_CSI
	} phase_t;

	// input stage
	logic              valid_s1;
	logic [7:0]        byte_s1;
	// result stage
	logic              valid_s2;
	aesp_pkg::kind_t   kind_s2;
	logic [1:0]        mode_s2;
	logic signed [16:0] amount_s2;
	logic [5:0]        id_s2;
	logic [7:0]        cs_s2;
	// parser state
	phase_t            phase_q;
	logic [15:0]       first_val_q;
	logic              first_dig_q;
	logic              first_done_q;
	logic [15:0]       whole_val_q;
	logic [1:0]        whole_stage_q;
	logic              whole_neg_q;
	logic              priv_q;
	logic [SEQ_W-1:0]  seq_cnt_q;
	logic [5:0]        pend_q;

	phase_t            phase_d;
	logic [15:0]       first_val_d;
	logic              first_dig_d;
	logic              first_done_d;
	logic [15:0]       whole_val_d;
	logic [1:0]        whole_stage_d;
	logic              whole_neg_d;
	logic              priv_d;
	logic [SEQ_W-1:0]  seq_cnt_d;
	logic [5:0]        pend_d;

	logic              emit;
	aesp_pkg::kind_t   r_kind;
	logic [1:0]        r_mode;
	logic signed [16:0] r_amount;
	logic [5:0]        r_id;
	logic [7:0]        r_cs;

	logic              advance;
	logic              fire;
	aesp_pkg::ctl_hit_t hit;
	logic              is_dig;
	logic              is_ws;
	logic              is_final;
	logic [3:0]        dig;
	logic signed [16:0] n_val;
	logic signed [16:0] w_val;
	logic              w_pos;

	assign advance       = !valid_s2 || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, cs_s2, id_s2, amount_s2, mode_s2, kind_s2};

	assign hit      = aesp_pkg::ctl_lookup(byte_s1);
	assign is_dig   = (byte_s1 >= aesp_pkg::CH_ZERO) && (byte_s1 <= aesp_pkg::CH_NINE);
	assign is_ws    = (byte_s1 == aesp_pkg::CH_SPACE) ||
	                  ((byte_s1 >= aesp_pkg::CH_WS_LO) && (byte_s1 <= aesp_pkg::CH_WS_HI));
	assign is_final = (byte_s1 >= aesp_pkg::FINAL_LO) && (byte_s1 <= aesp_pkg::FINAL_HI);
	assign dig      = byte_s1[3:0];

	assign n_val = $signed({1'b0, first_val_q});
	assign w_val = (whole_stage_q != 2'd2) ? 17'sd1 :
	               whole_neg_q ? -$signed({1'b0, whole_val_q}) : $signed({1'b0, whole_val_q});
	assign w_pos = (whole_stage_q != 2'd2) || (!whole_neg_q && (whole_val_q != 16'd0));

	always_comb begin
		phase_d       = phase_q;
		first_val_d   = first_val_q;
		first_dig_d   = first_dig_q;
		first_done_d  = first_done_q;
		whole_val_d   = whole_val_q;
		whole_stage_d = whole_stage_q;
		whole_neg_d   = whole_neg_q;
		priv_d        = priv_q;
		seq_cnt_d     = seq_cnt_q;
		pend_d        = pend_q;
		emit          = 1'b0;
		r_kind        = aesp_pkg::KIND_INVALID;
		r_mode        = 2'd0;
		r_amount      = 17'sd0;
		r_id          = 6'd0;
		r_cs          = 8'd0;

		case (phase_q)
			PH_IDLE: begin
				if (byte_s1 == aesp_pkg::KEY_ESC) begin
					phase_d = PH_ESC;
					seq_cnt_d = SEQ_W'(1);
				end else begin
					emit = 1'b1;
				end
			end
			PH_ESC: begin
				if (!hit.found) begin
					phase_d = PH_IDLE;
					emit = 1'b1;
				end else if (hit.id == aesp_pkg::ID_CSI) begin
					phase_d = PH_CSI;
					seq_cnt_d = SEQ_W'(2);
				end else if (hit.id >= aesp_pkg::ID_G0 && hit.id <= aesp_pkg::ID_G3) begin
					phase_d = PH_DESIG;
					pend_d = hit.id;
				end else begin
					phase_d = PH_IDLE;
					emit = 1'b1;
					r_kind = aesp_pkg::KIND_OTHER;
					r_id = hit.id;
				end
			end
			PH_DESIG: begin
				phase_d = PH_IDLE;
				emit = 1'b1;
				r_kind = aesp_pkg::KIND_OTHER;
				r_id = pend_q;
				r_cs = byte_s1;
			end
			PH_CSI: begin
				if (seq_cnt_q >= SEQ_W'(MAX_SEQ_LEN)) begin
					phase_d = PH_IDLE;
					emit = 1'b1;
				end else if (is_final) begin
					phase_d = PH_IDLE;
					emit = 1'b1;
					if (!priv_q) begin
						case (byte_s1)
							aesp_pkg::CH_J: begin
								r_kind = aesp_pkg::KIND_ERASE_DISP;
								r_mode = (first_val_q <= 16'd3) ? first_val_q[1:0] : 2'd0;
							end
							aesp_pkg::CH_K: begin
								r_kind = aesp_pkg::KIND_ERASE_LINE;
								r_mode = (first_val_q <= 16'd2) ? first_val_q[1:0] : 2'd0;
							end
							aesp_pkg::CH_S: begin
								r_kind = aesp_pkg::KIND_SCROLL;
								r_amount = (first_val_q != 16'd0) ? n_val : 17'sd1;
							end
							aesp_pkg::CH_T: begin
								r_kind = aesp_pkg::KIND_SCROLL;
								r_amount = (first_val_q != 16'd0) ? -n_val : -17'sd1;
							end
							aesp_pkg::CH_LS: begin
								r_kind = aesp_pkg::KIND_SAVE;
								r_amount = n_val;
							end
							aesp_pkg::CH_LU: begin
								r_kind = aesp_pkg::KIND_RESTORE;
								r_amount = n_val;
							end
							aesp_pkg::CH_LD: begin
								r_kind = aesp_pkg::KIND_ROW_ABS;
								r_amount = w_pos ? w_val : 17'sd1;
							end
							aesp_pkg::CH_LE: begin
								r_kind = aesp_pkg::KIND_ROW_REL;
								r_amount = w_val;
							end
							default: begin
								r_kind = aesp_pkg::KIND_INVALID;
							end
						endcase
					end
				end else begin
					seq_cnt_d = seq_cnt_q + SEQ_W'(1);
					if (seq_cnt_q == SEQ_W'(2) && byte_s1 == aesp_pkg::CH_QUERY)
						priv_d = 1'b1;
					if (!first_done_q) begin
						if (is_dig) begin
							first_val_d = aesp_pkg::sat_acc(first_val_q, dig);
							first_dig_d = 1'b1;
						end else if (byte_s1 == aesp_pkg::CH_SEMI ||
						             byte_s1 == aesp_pkg::CH_COLON || first_dig_q) begin
							first_done_d = 1'b1;
						end
					end
					case (whole_stage_q)
						2'd0: begin
							if (is_ws) begin
								whole_stage_d = 2'd0;
							end else if (byte_s1 == aesp_pkg::CH_PLUS) begin
								whole_stage_d = 2'd1;
							end else if (byte_s1 == aesp_pkg::CH_MINUS) begin
								whole_stage_d = 2'd1;
								whole_neg_d = 1'b1;
							end else if (is_dig) begin
								whole_stage_d = 2'd2;
								whole_val_d = {12'b0, dig};
							end else begin
								whole_stage_d = 2'd3;
							end
						end
						2'd1: begin
							if (is_dig) begin
								whole_stage_d = 2'd2;
								whole_val_d = {12'b0, dig};
							end else begin
								whole_stage_d = 2'd3;
							end
						end
						2'd2: begin
							if (is_dig)
								whole_val_d = aesp_pkg::sat_acc(whole_val_q, dig);
							else
								whole_stage_d = 2'd3;
						end
						default: begin
							whole_stage_d = 2'd3;
						end
					endcase
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// every return to idle clears the sequence state (all but pend_q)
		if (phase_d == PH_IDLE) begin
			first_val_d   = '0;
			first_dig_d   = 1'b0;
			first_done_d  = 1'b0;
			whole_val_d   = '0;
			whole_stage_d = 2'd0;
			whole_neg_d   = 1'b0;
			priv_d        = 1'b0;
			seq_cnt_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			byte_s1       <= '0;
			valid_s2      <= 1'b0;
			kind_s2       <= aesp_pkg::KIND_INVALID;
			mode_s2       <= '0;
			amount_s2     <= '0;
			id_s2         <= '0;
			cs_s2         <= '0;
			phase_q       <= PH_IDLE;
			first_val_q   <= '0;
			first_dig_q   <= 1'b0;
			first_done_q  <= 1'b0;
			whole_val_q   <= '0;
			whole_stage_q <= 2'd0;
			whole_neg_q   <= 1'b0;
			priv_q        <= 1'b0;
			seq_cnt_q     <= '0;
			pend_q        <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
				byte_s1  <= s_axis_tdata;
			end
			if (advance)
				valid_s2 <= fire && emit;
			if (fire) begin
				if (emit) begin
					kind_s2   <= r_kind;
					mode_s2   <= r_mode;
					amount_s2 <= r_amount;
					id_s2     <= r_id;
					cs_s2     <= r_cs;
				end
				phase_q       <= phase_d;
				first_val_q   <= first_val_d;
				first_dig_q   <= first_dig_d;
				first_done_q  <= first_done_d;
				whole_val_q   <= whole_val_d;
				whole_stage_q <= whole_stage_d;
				whole_neg_q   <= whole_neg_d;
				priv_q        <= priv_d;
				seq_cnt_q     <= seq_cnt_d;
				pend_q        <= pend_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> seq_cnt_q == '0 && !priv_q && whole_stage_q == 2'd0)
		else $error("sequence state not cleared in idle");

	a_csi_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CSI |-> seq_cnt_q >= SEQ_W'(2) && seq_cnt_q <= SEQ_W'(MAX_SEQ_LEN))
		else $error("sequence length out of bounds");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with result register empty");

	a_ctl_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && kind_s2 != aesp_pkg::KIND_OTHER |-> id_s2 == 6'd0 && cs_s2 == 8'd0)
		else $error("control fields set on non-control result");

	a_desig_pend: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DESIG |-> pend_q >= aesp_pkg::ID_G0 && pend_q <= aesp_pkg::ID_G3)
		else $error("designator pending without G0-G3 select");
`endif

endmodule

`default_nettype wire
